// ----- hdl/rtci_pkg.sv -----
package rtci_pkg;

    // Curve storage and field widths
    localparam int ROM_POINTS    = 31;
    localparam int CURVE_POINTS  = 31;
    localparam int FRACTION_BITS = 8;

    localparam int SPEED_W  = 16;
    localparam int TORQUE_W = 8;
    localparam int OUT_W    = 16;

    localparam int USED_POINTS = (CURVE_POINTS > ROM_POINTS) ? ROM_POINTS :
                                 (CURVE_POINTS < 2) ? 2 : CURVE_POINTS;
    localparam int SEGMENTS    = USED_POINTS - 1;
    localparam int SEG_IDX_W   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int FRAC_W      = (FRACTION_BITS > 16) ? 16 : FRACTION_BITS;

    // Datapath widths for the reciprocal divide
    localparam int NUM_W       = SPEED_W + TORQUE_W;
    localparam int RECIP_SHIFT = NUM_W + FRAC_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int QSPAN_W     = RECIP_SHIFT + SPEED_W;
    localparam int RES_W       = TORQUE_W + FRAC_W + 1;
    localparam int SAT_W       = (RES_W > OUT_W) ? RES_W : OUT_W + 1;

    localparam logic [SAT_W-1:0] OUT_MAX = SAT_W'({OUT_W{1'b1}});

    localparam logic [SPEED_W-1:0] SPEED_ROM [ROM_POINTS] = '{
        16'd0,    16'd800,  16'd1000, 16'd1200, 16'd1400, 16'd1600, 16'd1800,
        16'd2000, 16'd2200, 16'd2400, 16'd2600, 16'd2800, 16'd3000, 16'd3200,
        16'd3400, 16'd3600, 16'd3800, 16'd4000, 16'd4200, 16'd4400, 16'd4600,
        16'd4800, 16'd5000, 16'd5200, 16'd5400, 16'd5600, 16'd5800, 16'd6000,
        16'd6200, 16'd6400, 16'd6500
    };

    localparam logic [TORQUE_W-1:0] TORQUE_ROM [ROM_POINTS] = '{
        8'd0,   8'd106, 8'd114, 8'd122, 8'd130, 8'd137, 8'd143, 8'd148,
        8'd148, 8'd148, 8'd150, 8'd154, 8'd158, 8'd162, 8'd166, 8'd170,
        8'd174, 8'd174, 8'd174, 8'd170, 8'd164, 8'd161, 8'd159, 8'd160,
        8'd160, 8'd156, 8'd151, 8'd146, 8'd141, 8'd137, 8'd136
    };

endpackage

// ----- hdl/rtci_if.sv -----
interface rtci_speed_if;
    logic                            valid;
    logic                            ready;
    logic [rtci_pkg::SPEED_W-1:0]    engine_speed;

    modport source (output valid, output engine_speed, input ready);
    modport sink   (input valid, input engine_speed, output ready);
endinterface

interface rtci_torque_if;
    logic                            valid;
    logic                            ready;
    logic [rtci_pkg::OUT_W-1:0]      torque_fixed;

    modport source (output valid, output torque_fixed, input ready);
    modport sink   (input valid, input torque_fixed, output ready);
endinterface

// ----- hdl/rpm_torque_curve_interpolator_top.sv -----
// Seven register stages, each with its own valid bit; the last one is the output register.
// Throughput: one item per cycle while torque.ready does not stall the output.
// A stage loads whenever it is empty or the stage after it moves, so bubbles close up and a
// waiting result does not block new items until every stage is full.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers are not reset.
module rpm_torque_curve_interpolator_top (
    input  logic                 clk,
    input  logic                 rst_n,
    rtci_speed_if.sink           speed,
    rtci_torque_if.source        torque
);

    localparam int SEGS = rtci_pkg::SEGMENTS;
    localparam int LAST = rtci_pkg::USED_POINTS - 1;

    // ------------------------------------------------------------------
    // Per-segment constant tables, all worked out at elaboration.
    // A segment with no width (equal speed breakpoints) never hits.
    // ------------------------------------------------------------------
    logic [rtci_pkg::SPEED_W-1:0]  seg_lo_tab   [SEGS];
    logic [rtci_pkg::SPEED_W-1:0]  seg_span_tab [SEGS];
    logic [rtci_pkg::TORQUE_W-1:0] seg_mag_tab  [SEGS];
    logic                          seg_fall_tab [SEGS];
    logic [rtci_pkg::SAT_W-1:0]    seg_base_tab [SEGS];
    logic [rtci_pkg::RECIP_W-1:0]  seg_recip_tab[SEGS];
    logic [SEGS-1:0]               hit;

    for (genvar g = 0; g < SEGS; g++) begin : g_seg
        localparam logic [rtci_pkg::SPEED_W-1:0]  R0 = rtci_pkg::SPEED_ROM[g];
        localparam logic [rtci_pkg::SPEED_W-1:0]  R1 = rtci_pkg::SPEED_ROM[g+1];
        localparam logic [rtci_pkg::TORQUE_W-1:0] T0 = rtci_pkg::TORQUE_ROM[g];
        localparam logic [rtci_pkg::TORQUE_W-1:0] T1 = rtci_pkg::TORQUE_ROM[g+1];
        localparam bit VALID_SEG = (R1 > R0);
        localparam logic [rtci_pkg::SPEED_W-1:0] SPAN =
            VALID_SEG ? rtci_pkg::SPEED_W'(R1 - R0) : rtci_pkg::SPEED_W'(1);
        // floor(2^K / span): the estimate below is exact or one short
        localparam logic [rtci_pkg::RECIP_W-1:0] RECIP = rtci_pkg::RECIP_W'(
            (rtci_pkg::RECIP_W'(1) << rtci_pkg::RECIP_SHIFT) / rtci_pkg::RECIP_W'(SPAN));

        assign seg_lo_tab[g]    = R0;
        assign seg_span_tab[g]  = SPAN;
        assign seg_fall_tab[g]  = (T1 < T0);
        assign seg_mag_tab[g]   = (T1 < T0) ? rtci_pkg::TORQUE_W'(T0 - T1)
                                            : rtci_pkg::TORQUE_W'(T1 - T0);
        assign seg_base_tab[g]  = rtci_pkg::SAT_W'(T0) << rtci_pkg::FRAC_W;
        assign seg_recip_tab[g] = RECIP;

        assign hit[g] = VALID_SEG && (speed.engine_speed >= R0) && (speed.engine_speed <= R1);
    end

    localparam logic [rtci_pkg::SAT_W-1:0] FIRST_BASE =
        rtci_pkg::SAT_W'(rtci_pkg::TORQUE_ROM[0]) << rtci_pkg::FRAC_W;
    localparam logic [rtci_pkg::SAT_W-1:0] LAST_BASE =
        rtci_pkg::SAT_W'(rtci_pkg::TORQUE_ROM[LAST]) << rtci_pkg::FRAC_W;

    // ------------------------------------------------------------------
    // Stage handshake: each stage advances when empty or when the next moves
    // ------------------------------------------------------------------
    logic [7:1] v_reg;
    logic [7:1] en;

    always_comb
    begin
        en[7] = !v_reg[7] || torque.ready;
        for (int k = 6; k >= 1; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign speed.ready  = en[1];
    assign torque.valid = v_reg[7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= speed.valid;
            end
            for (int k = 2; k <= 7; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: compare the speed against every segment and both ends
    // ------------------------------------------------------------------
    logic [rtci_pkg::SPEED_W-1:0] rpm1_reg;
    logic [SEGS-1:0]              hit1_reg;
    logic                         below1_reg;
    logic                         above1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rpm1_reg   <= speed.engine_speed;
            hit1_reg   <= hit;
            below1_reg <= (speed.engine_speed <= rtci_pkg::SPEED_ROM[0]);
            above1_reg <= (speed.engine_speed >= rtci_pkg::SPEED_ROM[LAST]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: pick the first bracketing segment and fetch its constants.
    // Clamped speeds run through with zero slope and the end torque as base.
    // ------------------------------------------------------------------
    logic [rtci_pkg::SEG_IDX_W-1:0] idx;
    logic                           found;
    logic [rtci_pkg::SPEED_W-1:0]   offset2_next;
    logic [rtci_pkg::TORQUE_W-1:0]  mag2_next;
    logic                           fall2_next;
    logic [rtci_pkg::SAT_W-1:0]     base2_next;
    logic [rtci_pkg::SPEED_W-1:0]   span2_next;
    logic [rtci_pkg::RECIP_W-1:0]   recip2_next;

    always_comb
    begin
        idx   = '0;
        found = 1'b0;
        for (int s = SEGS - 1; s >= 0; s--)
        begin
            if (hit1_reg[s])
            begin
                idx   = rtci_pkg::SEG_IDX_W'(s);
                found = 1'b1;
            end
        end

        offset2_next = rpm1_reg - seg_lo_tab[idx];
        mag2_next    = seg_mag_tab[idx];
        fall2_next   = seg_fall_tab[idx];
        base2_next   = seg_base_tab[idx];
        span2_next   = seg_span_tab[idx];
        recip2_next  = seg_recip_tab[idx];

        if (below1_reg || above1_reg || !found)
        begin
            offset2_next = '0;
            mag2_next    = '0;
            fall2_next   = 1'b0;
            base2_next   = below1_reg ? FIRST_BASE : LAST_BASE;
            span2_next   = rtci_pkg::SPEED_W'(1);
            recip2_next  = '0;
        end
    end

    logic [rtci_pkg::SPEED_W-1:0]  offset2_reg;
    logic [rtci_pkg::TORQUE_W-1:0] mag2_reg;
    logic                          fall2_reg;
    logic [rtci_pkg::SAT_W-1:0]    base2_reg;
    logic [rtci_pkg::SPEED_W-1:0]  span2_reg;
    logic [rtci_pkg::RECIP_W-1:0]  recip2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            offset2_reg <= offset2_next;
            mag2_reg    <= mag2_next;
            fall2_reg   <= fall2_next;
            base2_reg   <= base2_next;
            span2_reg   <= span2_next;
            recip2_reg  <= recip2_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: numerator = offset into segment * torque step
    // ------------------------------------------------------------------
    logic [rtci_pkg::NUM_W-1:0]   num3_reg;
    logic                         fall3_reg;
    logic [rtci_pkg::SAT_W-1:0]   base3_reg;
    logic [rtci_pkg::SPEED_W-1:0] span3_reg;
    logic [rtci_pkg::RECIP_W-1:0] recip3_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            num3_reg   <= rtci_pkg::NUM_W'(offset2_reg) * rtci_pkg::NUM_W'(mag2_reg);
            fall3_reg  <= fall2_reg;
            base3_reg  <= base2_reg;
            span3_reg  <= span2_reg;
            recip3_reg <= recip2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: multiply by the segment reciprocal
    // ------------------------------------------------------------------
    logic [rtci_pkg::PROD_W-1:0]  prod4_reg;
    logic [rtci_pkg::NUM_W-1:0]   num4_reg;
    logic                         fall4_reg;
    logic [rtci_pkg::SAT_W-1:0]   base4_reg;
    logic [rtci_pkg::SPEED_W-1:0] span4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            prod4_reg <= rtci_pkg::PROD_W'(num3_reg) * rtci_pkg::PROD_W'(recip3_reg);
            num4_reg  <= num3_reg;
            fall4_reg <= fall3_reg;
            base4_reg <= base3_reg;
            span4_reg <= span3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: quotient estimate (shift drops K - F bits) and its back product
    // ------------------------------------------------------------------
    logic [rtci_pkg::RECIP_SHIFT-1:0] qest;

    assign qest = prod4_reg[rtci_pkg::NUM_W +: rtci_pkg::RECIP_SHIFT];

    logic [rtci_pkg::RECIP_SHIFT-1:0] qest5_reg;
    logic [rtci_pkg::QSPAN_W-1:0]     qspan5_reg;
    logic [rtci_pkg::NUM_W-1:0]       num5_reg;
    logic                             fall5_reg;
    logic [rtci_pkg::SAT_W-1:0]       base5_reg;
    logic [rtci_pkg::SPEED_W-1:0]     span5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            qest5_reg  <= qest;
            qspan5_reg <= rtci_pkg::QSPAN_W'(qest) * rtci_pkg::QSPAN_W'(span4_reg);
            num5_reg   <= num4_reg;
            fall5_reg  <= fall4_reg;
            base5_reg  <= base4_reg;
            span5_reg  <= span4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: correct the estimate by one where the remainder reaches the span
    // ------------------------------------------------------------------
    logic [rtci_pkg::QSPAN_W-1:0] numf;
    logic [rtci_pkg::QSPAN_W-1:0] rem;

    assign numf = rtci_pkg::QSPAN_W'(num5_reg) << rtci_pkg::FRAC_W;
    assign rem  = numf - qspan5_reg;

    logic [rtci_pkg::RECIP_SHIFT-1:0] q6_reg;
    logic                             fall6_reg;
    logic [rtci_pkg::SAT_W-1:0]       base6_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            q6_reg    <= qest5_reg + rtci_pkg::RECIP_SHIFT'(rem >= rtci_pkg::QSPAN_W'(span5_reg));
            fall6_reg <= fall5_reg;
            base6_reg <= base5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: apply the fraction to the base torque, saturate, hold for output
    // ------------------------------------------------------------------
    logic [rtci_pkg::SAT_W-1:0] q_ext;
    logic [rtci_pkg::SAT_W-1:0] sum;

    assign q_ext = rtci_pkg::SAT_W'(q6_reg);
    assign sum   = fall6_reg ? (base6_reg - q_ext) : (base6_reg + q_ext);

    logic [rtci_pkg::OUT_W-1:0] torque7_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            torque7_reg <= (sum > rtci_pkg::OUT_MAX) ? {rtci_pkg::OUT_W{1'b1}}
                                                      : rtci_pkg::OUT_W'(sum);
        end
    end

    assign torque.torque_fixed = torque7_reg;

endmodule

// ----- tb/torque_curve_checker.sv -----
module torque_curve_checker (
    input  logic          clk,
    input  logic          rst_n,
    rtci_speed_if         speed,
    rtci_torque_if        torque,
    output int unsigned   mismatch_count,
    output int unsigned   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [rtci_pkg::OUT_W-1:0] torque_due [$];

    // Piecewise linear torque for one speed, fixed point with FRAC_W fraction bits.
    function automatic logic [rtci_pkg::OUT_W-1:0] curve_torque(
        input logic [rtci_pkg::SPEED_W-1:0] rpm);
        longint unsigned scale;
        longint unsigned r0;
        longint unsigned r1;
        longint unsigned t0;
        longint unsigned t1;
        longint unsigned q;
        longint unsigned mag;
        longint unsigned res;
        bit              found;
        scale = 64'd1 << rtci_pkg::FRAC_W;
        found = 1'b0;
        res   = longint'(rtci_pkg::TORQUE_ROM[rtci_pkg::USED_POINTS-1]) * scale;
        if (rpm <= rtci_pkg::SPEED_ROM[0])
        begin
            res = longint'(rtci_pkg::TORQUE_ROM[0]) * scale;
        end
        else if (rpm < rtci_pkg::SPEED_ROM[rtci_pkg::USED_POINTS-1])
        begin
            for (int i = 0; i + 1 < rtci_pkg::USED_POINTS; i++)
            begin
                r0 = rtci_pkg::SPEED_ROM[i];
                r1 = rtci_pkg::SPEED_ROM[i+1];
                t0 = rtci_pkg::TORQUE_ROM[i];
                t1 = rtci_pkg::TORQUE_ROM[i+1];
                if (!found && rpm >= r0 && rpm <= r1 && r1 > r0)
                begin
                    found = 1'b1;
                    mag   = (t1 < t0) ? (t0 - t1) : (t1 - t0);
                    q     = ((longint'(rpm) - r0) * mag * scale) / (r1 - r0);
                    res   = (t1 < t0) ? (t0 * scale - q) : (t0 * scale + q);
                end
            end
        end
        if (res > 64'hFFFF)
            res = 64'hFFFF;
        return res[rtci_pkg::OUT_W-1:0];
    endfunction

    // Sample both channels on the rising edge, before the block updates.
    always @(posedge clk)
    begin
        logic [rtci_pkg::OUT_W-1:0] want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (speed.valid && speed.ready)
                torque_due.push_back(curve_torque(speed.engine_speed));
            if (torque.valid && torque.ready)
            begin
                if (torque_due.size() == 0)
                begin
                    $error("torque_fixed: expected none, actual %0d", torque.torque_fixed);
                    mismatch_count++;
                end
                else
                begin
                    want = torque_due.pop_front();
                    if (torque.torque_fixed !== want)
                    begin
                        $error("torque_fixed: expected %0d, actual %0d",
                               want, torque.torque_fixed);
                        mismatch_count++;
                    end
                end
            end
            pending_count = torque_due.size();
        end
    end

endmodule

// ----- tb/tb_rpm_torque_curve_interpolator_top.sv -----
module tb_rpm_torque_curve_interpolator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 4;
    localparam int DRAIN_CYCLES = 20;   // block latency is seven stages; allow margin

    logic        clk;
    logic        rst_n;
    int unsigned mismatch_count;
    int unsigned pending_count;

    // Percent of cycles in which the sender holds off / the receiver stalls.
    int unsigned sender_idle_pct;
    int unsigned recv_stall_pct;

    rtci_speed_if  speed_ch ();
    rtci_torque_if torque_ch ();

    rpm_torque_curve_interpolator_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .speed  (speed_ch),
        .torque (torque_ch)
    );

    torque_curve_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .speed          (speed_ch),
        .torque         (torque_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Drive every input to a known value from time zero.
    initial
    begin
        rst_n                 = 1'b0;
        speed_ch.valid        = 1'b0;
        speed_ch.engine_speed = '0;
        torque_ch.ready       = 1'b0;
        sender_idle_pct       = 0;
        recv_stall_pct        = 0;
    end

    // Receiver side: decide ready once per falling edge, so the checker and
    // the block both see a stable value at the next rising edge.
    always @(negedge clk)
    begin
        torque_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one speed item and hold it until the block takes it.
    // Called at a falling edge; returns at a falling edge with valid still high,
    // so back-to-back items never see valid dropped and raised in one step.
    task automatic send_speed(input logic [rtci_pkg::SPEED_W-1:0] rpm);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            speed_ch.valid <= 1'b0;
            @(negedge clk);
        end
        speed_ch.valid        <= 1'b1;
        speed_ch.engine_speed <= rpm;
        do
            @(posedge clk);
        while (!speed_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and hold the sender until every predicted torque has come back.
    task automatic drain_results();
        speed_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Random speed: mostly inside the curve, some right on or next to a
    // breakpoint, the rest anywhere in the 16-bit range (flat top region).
    function automatic logic [rtci_pkg::SPEED_W-1:0] pick_speed();
        int unsigned sel;
        int          bp;
        int          near;
        sel = $urandom_range(99);
        if (sel < 65)
            return rtci_pkg::SPEED_W'($urandom_range(6700));
        if (sel < 80)
        begin
            bp   = rtci_pkg::SPEED_ROM[$urandom_range(rtci_pkg::ROM_POINTS-1)];
            near = bp + int'($urandom_range(6)) - 3;
            if (near < 0)
                near = 0;
            return rtci_pkg::SPEED_W'(near);
        end
        return rtci_pkg::SPEED_W'($urandom_range(65535));
    endfunction

    logic [rtci_pkg::SPEED_W-1:0] directed_speeds [$] = '{
        16'd0,     16'd1,     16'd400,   16'd799,   16'd800,   16'd801,
        16'd1000,  16'd1099,  16'd2100,  16'd3999,  16'd4000,  16'd4100,
        16'd4500,  16'd5100,  16'd5650,  16'd6450,  16'd6499,  16'd6500,
        16'd6501,  16'd32768, 16'hAAAA,  16'h5555,  16'hFFFE,  16'hFFFF
    };

    initial
    begin
        // Hold reset, then release it once, away from the rising edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: curve ends, breakpoints, flat, rising and falling segments,
        // speeds far past the last breakpoint and the full-scale extremes.
        foreach (directed_speeds[k])
            send_speed(directed_speeds[k]);
        drain_results();

        // Random: four pressure phases, each ending with the sender paused
        // until the pipeline is empty.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 64;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 64;
                end
                default:
                begin
                    sender_idle_pct = 21;
                    recv_stall_pct  = 21;
                end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_speed(pick_speed());
            drain_results();
        end

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of about 1300 items.
    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
